// ===== sv/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cruise PI controller package
// Shared types, codes, reset values and the control store of the sequencer.
// ----------------------------------------------------------------------------
package cpc_pkg;

   localparam int PcWidth = 5;
   typedef logic [PcWidth-1:0] cpc_pc_type;

   typedef enum logic [2:0] {
      MODE_SAMPLE    = 3'd0,
      MODE_TICK      = 3'd1,
      MODE_ENGAGE    = 3'd2,
      MODE_DISENGAGE = 3'd3,
      MODE_SET_SPEED = 3'd4,
      MODE_RESUME    = 3'd5
   } cpc_mode_type;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_STEP_TIME      = 3'd2,
      CSR_THROTTLE_LIMIT = 3'd3,
      CSR_READY_RPM      = 3'd4
   } cpc_csr_type;

   localparam logic [15:0] PropGainReset      = 16'd52429;
   localparam logic [15:0] IntegGainReset     = 16'd6554;
   localparam logic [15:0] StepTimeReset      = 16'd3277;
   localparam logic [14:0] ThrottleLimitReset = 15'd25600;
   localparam logic [13:0] ReadyRpmReset      = 14'd50;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SAMPLE,
      OP_ENGAGE,
      OP_DISENGAGE,
      OP_SET_SPEED,
      OP_RESUME,
      OP_MUL_DT,
      OP_INTEG,
      OP_PROP,
      OP_SUM,
      OP_CLAMP
   } cpc_op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_ACTIVE,
      COND_IDLE,
      COND_PEDAL,
      COND_NO_SAVED
   } cpc_cond_type;

   typedef struct packed {
      cpc_op_type   op;
      cpc_cond_type cond;
      cpc_pc_type   target;
      logic         done;
   } cpc_uword_type;

   typedef struct packed {
      cpc_op_type op;
      logic       exec;
      logic       emit;
   } cpc_ctrl_type;

   typedef struct packed {
      logic active;
      logic pedal;
      logic no_saved;
   } cpc_flags_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] speed_value;
      logic [13:0] engine_rpm;
      logic [14:0] pedal_throttle;
      logic        brake_on;
      logic        clutch_on;
   } cpc_item_type;

   typedef struct packed {
      logic [14:0] throttle_cmd;
      logic        engaged;
      logic [15:0] target_speed;
      logic [15:0] saved_speed;
      logic        ready_pulse;
   } cpc_result_type;

   localparam cpc_pc_type PC_EMIT       = 5'd0;
   localparam cpc_pc_type PC_SAMPLE     = 5'd1;
   localparam cpc_pc_type PC_TICK       = 5'd2;
   localparam cpc_pc_type PC_TICK_DROP  = 5'd9;
   localparam cpc_pc_type PC_ENGAGE     = 5'd10;
   localparam cpc_pc_type PC_DISENGAGE  = 5'd12;
   localparam cpc_pc_type PC_SET_SPEED  = 5'd14;
   localparam cpc_pc_type PC_RESUME     = 5'd16;

   function automatic cpc_pc_type cpc_dispatch(input logic [2:0] mode);
      cpc_pc_type pc;
      case (mode)
         MODE_SAMPLE:    pc = PC_SAMPLE;
         MODE_TICK:      pc = PC_TICK;
         MODE_ENGAGE:    pc = PC_ENGAGE;
         MODE_DISENGAGE: pc = PC_DISENGAGE;
         MODE_SET_SPEED: pc = PC_SET_SPEED;
         MODE_RESUME:    pc = PC_RESUME;
         default:        pc = PC_EMIT;
      endcase
      return pc;
   endfunction

   function automatic cpc_uword_type cpc_urom(input cpc_pc_type pc);
      cpc_uword_type uw;
      case (pc)
         5'd0:    uw = '{OP_NOP,       COND_NEXT,     PC_EMIT,      1'b1};
         5'd1:    uw = '{OP_SAMPLE,    COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd2:    uw = '{OP_NOP,       COND_IDLE,     PC_EMIT,      1'b0};
         5'd3:    uw = '{OP_NOP,       COND_PEDAL,    PC_TICK_DROP, 1'b0};
         5'd4:    uw = '{OP_MUL_DT,    COND_NEXT,     PC_EMIT,      1'b0};
         5'd5:    uw = '{OP_INTEG,     COND_NEXT,     PC_EMIT,      1'b0};
         5'd6:    uw = '{OP_PROP,      COND_NEXT,     PC_EMIT,      1'b0};
         5'd7:    uw = '{OP_SUM,       COND_NEXT,     PC_EMIT,      1'b0};
         5'd8:    uw = '{OP_CLAMP,     COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd9:    uw = '{OP_DISENGAGE, COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd10:   uw = '{OP_NOP,       COND_ACTIVE,   PC_EMIT,      1'b0};
         5'd11:   uw = '{OP_ENGAGE,    COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd12:   uw = '{OP_NOP,       COND_IDLE,     PC_EMIT,      1'b0};
         5'd13:   uw = '{OP_DISENGAGE, COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd14:   uw = '{OP_NOP,       COND_IDLE,     PC_EMIT,      1'b0};
         5'd15:   uw = '{OP_SET_SPEED, COND_ALWAYS,   PC_EMIT,      1'b0};
         5'd16:   uw = '{OP_NOP,       COND_NO_SAVED, PC_EMIT,      1'b0};
         5'd17:   uw = '{OP_RESUME,    COND_ALWAYS,   PC_ENGAGE,    1'b0};
         default: uw = '{OP_NOP,       COND_ALWAYS,   PC_EMIT,      1'b0};
      endcase
      return uw;
   endfunction

endpackage

// ===== sv/cpc_channels.sv =====
// ----------------------------------------------------------------------------
// Cruise PI controller channels
// Valid/ready interfaces for the event words and the result words.
// ----------------------------------------------------------------------------
interface cpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] speed_value;
   logic [13:0] engine_rpm;
   logic [14:0] pedal_throttle;
   logic        brake_on;
   logic        clutch_on;

   modport source (
      output valid, mode, speed_value, engine_rpm, pedal_throttle, brake_on, clutch_on,
      input  ready
   );
   modport sink (
      input  valid, mode, speed_value, engine_rpm, pedal_throttle, brake_on, clutch_on,
      output ready
   );
endinterface

interface cpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] throttle_cmd;
   logic        engaged;
   logic [15:0] target_speed;
   logic [15:0] saved_speed;
   logic        ready_pulse;

   modport source (
      output valid, throttle_cmd, engaged, target_speed, saved_speed, ready_pulse,
      input  ready
   );
   modport sink (
      input  valid, throttle_cmd, engaged, target_speed, saved_speed, ready_pulse,
      output ready
   );
endinterface

// ===== sv/cpc_sequencer.sv =====
// ----------------------------------------------------------------------------
// Cruise PI controller sequencer
// Step counter over the control store, with dispatch on the event mode and
// conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module cpc_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            mode,
   input  logic                  stall,
   input  cpc_pkg::cpc_flags_type flags,
   output logic                  busy,
   output cpc_pkg::cpc_ctrl_type ctrl
);

   logic                   busy_ff, busy_in;
   cpc_pkg::cpc_pc_type    pc_ff, pc_in;
   cpc_pkg::cpc_uword_type uw;
   logic                   taken;

   always_comb begin
      uw = cpc_pkg::cpc_urom(pc_ff);
      case (uw.cond)
         cpc_pkg::COND_NEXT:     taken = 1'b0;
         cpc_pkg::COND_ALWAYS:   taken = 1'b1;
         cpc_pkg::COND_ACTIVE:   taken = flags.active;
         cpc_pkg::COND_IDLE:     taken = !flags.active;
         cpc_pkg::COND_PEDAL:    taken = flags.pedal;
         cpc_pkg::COND_NO_SAVED: taken = flags.no_saved;
         default:                taken = 1'b0;
      endcase

      ctrl.op   = uw.op;
      ctrl.exec = busy_ff && !(uw.done && stall);
      ctrl.emit = busy_ff && uw.done && !stall;

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = cpc_pkg::cpc_dispatch(mode);
      end else if (ctrl.exec) begin
         if (uw.done) begin
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + cpc_pkg::cpc_pc_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= cpc_pkg::PC_EMIT;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== sv/cpc_datapath.sv =====
// ----------------------------------------------------------------------------
// Cruise PI controller datapath
// Control registers, controller state, the latched event word and one shared
// registered multiplier for the PI step.
// ----------------------------------------------------------------------------
module cpc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cpc_pkg::cpc_item_type   item,
   input  cpc_pkg::cpc_ctrl_type   ctrl,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_write_data,
   output cpc_pkg::cpc_flags_type  flags,
   output cpc_pkg::cpc_result_type result
);

   logic [15:0] prop_gain_ff, integ_gain_ff, step_time_ff;
   logic [14:0] throttle_limit_ff;
   logic [13:0] ready_rpm_ff;

   cpc_pkg::cpc_item_type item_ff;

   logic        active_ff, active_in;
   logic        pending_ff, pending_in;
   logic [15:0] set_speed_ff, set_speed_in;
   logic [15:0] last_speed_ff, last_speed_in;
   logic [15:0] meas_speed_ff, meas_speed_in;
   logic [14:0] meas_thr_ff, meas_thr_in;
   logic        brake_ff, brake_in;
   logic        clutch_ff, clutch_in;
   logic        was_ready_ff, was_ready_in;
   logic        pulse_ff, pulse_in;
   logic [31:0] integ_ff, integ_in;
   logic [14:0] throttle_ff, throttle_in;

   logic signed [48:0] prod_ff, prod_in;
   logic signed [49:0] total_ff, total_in;

   logic signed [16:0] err;
   logic signed [31:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [32:0] integ_sum;
   logic signed [25:0] pi_out;
   logic signed [26:0] thr_sum;
   logic               rpm_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= cpc_pkg::PropGainReset;
         integ_gain_ff     <= cpc_pkg::IntegGainReset;
         step_time_ff      <= cpc_pkg::StepTimeReset;
         throttle_limit_ff <= cpc_pkg::ThrottleLimitReset;
         ready_rpm_ff      <= cpc_pkg::ReadyRpmReset;
      end else if (csr_write_en) begin
         case (csr_index)
            cpc_pkg::CSR_PROP_GAIN:      prop_gain_ff      <= csr_write_data;
            cpc_pkg::CSR_INTEG_GAIN:     integ_gain_ff     <= csr_write_data;
            cpc_pkg::CSR_STEP_TIME:      step_time_ff      <= csr_write_data;
            cpc_pkg::CSR_THROTTLE_LIMIT: throttle_limit_ff <= csr_write_data[14:0];
            cpc_pkg::CSR_READY_RPM:      ready_rpm_ff      <= csr_write_data[13:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      err       = $signed({1'b0, set_speed_ff}) - $signed({1'b0, meas_speed_ff});
      integ_sum = $signed({integ_ff[31], integ_ff}) + 33'($signed(prod_ff[32:8]));
      pi_out    = total_ff[49:24];
      thr_sum   = $signed({12'd0, throttle_ff}) + 27'(pi_out);
      rpm_low   = item_ff.engine_rpm < ready_rpm_ff;

      case (ctrl.op)
         cpc_pkg::OP_PROP: begin
            mul_a = $signed(integ_ff);
            mul_b = $signed({1'b0, integ_gain_ff});
         end
         cpc_pkg::OP_INTEG: begin
            mul_a = 32'(err);
            mul_b = $signed({1'b0, prop_gain_ff});
         end
         default: begin
            mul_a = 32'(err);
            mul_b = $signed({1'b0, step_time_ff});
         end
      endcase
      prod_in = 49'(mul_a) * 49'(mul_b);

      active_in     = active_ff;
      pending_in    = pending_ff;
      set_speed_in  = set_speed_ff;
      last_speed_in = last_speed_ff;
      meas_speed_in = meas_speed_ff;
      meas_thr_in   = meas_thr_ff;
      brake_in      = brake_ff;
      clutch_in     = clutch_ff;
      was_ready_in  = was_ready_ff;
      pulse_in      = pulse_ff;
      integ_in      = integ_ff;
      throttle_in   = throttle_ff;
      total_in      = total_ff;

      if (start) begin
         pulse_in = 1'b0;
      end else if (ctrl.exec) begin
         case (ctrl.op)
            cpc_pkg::OP_SAMPLE: begin
               meas_speed_in = item_ff.speed_value;
               meas_thr_in   = item_ff.pedal_throttle;
               brake_in      = item_ff.brake_on;
               clutch_in     = item_ff.clutch_on;
               pulse_in      = rpm_low && !was_ready_ff;
               was_ready_in  = rpm_low;
            end
            cpc_pkg::OP_ENGAGE: begin
               active_in = 1'b1;
               if (!pending_ff) begin
                  set_speed_in  = meas_speed_ff;
                  last_speed_in = meas_speed_ff;
               end
               pending_in  = 1'b0;
               throttle_in = meas_thr_ff;
               integ_in    = '0;
            end
            cpc_pkg::OP_DISENGAGE: begin
               active_in  = 1'b0;
               pending_in = 1'b0;
            end
            cpc_pkg::OP_SET_SPEED: begin
               set_speed_in  = item_ff.speed_value;
               last_speed_in = item_ff.speed_value;
            end
            cpc_pkg::OP_RESUME: begin
               set_speed_in = last_speed_ff;
               pending_in   = 1'b1;
            end
            cpc_pkg::OP_INTEG: begin
               if (integ_sum[32] != integ_sum[31]) begin
                  integ_in = integ_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  integ_in = integ_sum[31:0];
               end
            end
            cpc_pkg::OP_PROP: begin
               total_in = $signed({prod_ff[41:0], 8'd0});
            end
            cpc_pkg::OP_SUM: begin
               total_in = total_ff + 50'(prod_ff);
            end
            cpc_pkg::OP_CLAMP: begin
               if (thr_sum[26]) begin
                  throttle_in = '0;
               end else if (thr_sum[25:0] > {11'd0, throttle_limit_ff}) begin
                  throttle_in = throttle_limit_ff;
               end else begin
                  throttle_in = thr_sum[14:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         set_speed_ff  <= '0;
         last_speed_ff <= '0;
         meas_speed_ff <= '0;
         meas_thr_ff   <= '0;
         brake_ff      <= 1'b0;
         clutch_ff     <= 1'b0;
         was_ready_ff  <= 1'b0;
         pulse_ff      <= 1'b0;
         integ_ff      <= '0;
         throttle_ff   <= '0;
      end else begin
         active_ff     <= active_in;
         pending_ff    <= pending_in;
         set_speed_ff  <= set_speed_in;
         last_speed_ff <= last_speed_in;
         meas_speed_ff <= meas_speed_in;
         meas_thr_ff   <= meas_thr_in;
         brake_ff      <= brake_in;
         clutch_ff     <= clutch_in;
         was_ready_ff  <= was_ready_in;
         pulse_ff      <= pulse_in;
         integ_ff      <= integ_in;
         throttle_ff   <= throttle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= item;
      end
      prod_ff  <= prod_in;
      total_ff <= total_in;
   end

   assign flags.active   = active_ff;
   assign flags.pedal    = brake_ff || clutch_ff;
   assign flags.no_saved = (last_speed_ff == 16'd0);

   assign result.throttle_cmd = throttle_ff;
   assign result.engaged      = active_ff;
   assign result.target_speed = set_speed_ff;
   assign result.saved_speed  = last_speed_ff;
   assign result.ready_pulse  = pulse_ff;

endmodule

// ===== sv/cruise_pi_controller_top.sv =====
// ----------------------------------------------------------------------------
// Cruise PI controller
// Event engine for cruise control: sample, tick, engage, disengage, set speed
// and resume, with a PI step on a tick that adds to the held throttle.
//
//   Channel   Direction  Handshake        Word
//   req_chan  in         valid / ready    mode, speed, rpm, throttle, pedals
//   rsp_chan  out        valid / ready    throttle, engaged, speeds, ready
//   csr_*     in         write enable     register index, write data
//
// One event word is in work at a time. A PI tick takes the most microprogram
// steps from acceptance to its result word, since its three products share
// one registered multiplier across the microprogram steps.
// A result word waits in an output register, so the next event word is
// accepted while it is not yet taken. Reset is synchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module cruise_pi_controller_top (
   input  logic        clock,
   input  logic        reset,
   cpc_req_if.sink     req_chan,
   cpc_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cpc_pkg::cpc_item_type   item;
   cpc_pkg::cpc_ctrl_type   ctrl;
   cpc_pkg::cpc_flags_type  flags;
   cpc_pkg::cpc_result_type result;
   cpc_pkg::cpc_result_type rsp_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    busy;
   logic                    start;
   logic                    stall;

   assign item.mode           = req_chan.mode;
   assign item.speed_value    = req_chan.speed_value;
   assign item.engine_rpm     = req_chan.engine_rpm;
   assign item.pedal_throttle = req_chan.pedal_throttle;
   assign item.brake_on       = req_chan.brake_on;
   assign item.clutch_on      = req_chan.clutch_on;

   assign req_chan.ready = !busy;
   assign start          = req_chan.valid && !busy;
   assign stall          = rsp_valid_ff && !rsp_chan.ready;

   cpc_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_chan.mode),
      .stall (stall),
      .flags (flags),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   cpc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .item           (item),
      .ctrl           (ctrl),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .flags          (flags),
      .result         (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.throttle_cmd = rsp_word_ff.throttle_cmd;
   assign rsp_chan.engaged      = rsp_word_ff.engaged;
   assign rsp_chan.target_speed = rsp_word_ff.target_speed;
   assign rsp_chan.saved_speed  = rsp_word_ff.saved_speed;
   assign rsp_chan.ready_pulse  = rsp_word_ff.ready_pulse;

`ifndef ASSERT_OFF
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("Event word accepted while another is in work.");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |=> rsp_chan.valid)
      else $error("Finished result word did not reach the output.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("Result word overwrote one not yet taken.");
`endif

endmodule

// ===== test/cruise_pi_controller_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cruise PI controller testbench
// Drives event words through the request channel and checks every result
// word against a cycle-free model of the controller state: sampling, engage,
// disengage, set speed, resume and the saturating PI tick. The run goes
// through several register settings, with random gaps on both channels and
// one long hold of the result channel.
// ----------------------------------------------------------------------------
module cruise_pi_controller_top_tb;

   localparam logic [2:0] ModeSpareLo   = 3'd6;
   localparam logic [2:0] ModeSpareHi   = 3'd7;
   localparam int         ClockHalf     = 5;
   localparam int         ResetCycles   = 5;
   localparam int         WatchdogLimit = 2000;
   localparam int         HoldCycles    = 400;
   localparam int         DrainCycles   = 20;
   localparam int         WindupTicks   = 140;
   localparam longint     IntegMax      = 64'sd2147483647;
   localparam longint     IntegMin      = -64'sd2147483648;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_write_data = 16'd0;

   cpc_req_if req_chan ();
   cpc_rsp_if rsp_chan ();

   cruise_pi_controller_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #ClockHalf clock = ~clock;

   // Register copies.
   logic [15:0] kp_gain    = cpc_pkg::PropGainReset;
   logic [15:0] ki_gain    = cpc_pkg::IntegGainReset;
   logic [15:0] dt_step    = cpc_pkg::StepTimeReset;
   logic [14:0] thr_limit  = cpc_pkg::ThrottleLimitReset;
   logic [13:0] rpm_thresh = cpc_pkg::ReadyRpmReset;

   // Controller state.
   logic        cc_active   = 1'b0;
   logic        resume_pend = 1'b0;
   logic [15:0] target_q    = 16'd0;
   logic [15:0] saved_q     = 16'd0;
   logic [15:0] meas_speed  = 16'd0;
   logic [14:0] meas_thr    = 15'd0;
   logic        brake_q     = 1'b0;
   logic        clutch_q    = 1'b0;
   int          integ_q     = 0;
   logic [14:0] throttle_q  = 15'd0;
   logic        was_below   = 1'b0;

   cpc_pkg::cpc_item_type   event_queue[$];
   cpc_pkg::cpc_result_type expected_results[$];
   cpc_pkg::cpc_item_type   next_word;
   cpc_pkg::cpc_item_type   taken_word;
   cpc_pkg::cpc_result_type seen_word;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;
   int phase_items    = 0;
   int events_taken   = 0;
   int results_seen   = 0;
   int fail_count     = 0;

   function automatic void cc_engage();
      if (!cc_active) begin
         cc_active = 1'b1;
         if (!resume_pend) begin
            target_q = meas_speed;
            saved_q  = meas_speed;
         end
         resume_pend = 1'b0;
         throttle_q  = meas_thr;
         integ_q     = 0;
      end
   endfunction

   function automatic void cc_disengage();
      if (cc_active) begin
         cc_active   = 1'b0;
         resume_pend = 1'b0;
      end
   endfunction

   function automatic cpc_pkg::cpc_result_type cruise_predict(
      input cpc_pkg::cpc_item_type ev);
      cpc_pkg::cpc_result_type res;
      logic           below;
      logic           pulse;
      longint         err;
      longint         acc;
      longint         total;
      longint         thr;
      pulse = 1'b0;
      case (ev.mode)
         cpc_pkg::MODE_SAMPLE: begin
            below      = ev.engine_rpm < rpm_thresh;
            meas_speed = ev.speed_value;
            meas_thr   = ev.pedal_throttle;
            brake_q    = ev.brake_on;
            clutch_q   = ev.clutch_on;
            pulse      = below && !was_below;
            was_below  = below;
         end
         cpc_pkg::MODE_TICK: begin
            if (cc_active) begin
               if (brake_q || clutch_q) begin
                  cc_disengage();
               end else begin
                  err = longint'(target_q) - longint'(meas_speed);
                  acc = longint'(integ_q) + ((err * longint'(dt_step)) >>> 8);
                  if (acc > IntegMax) acc = IntegMax;
                  if (acc < IntegMin) acc = IntegMin;
                  integ_q = int'(acc);
                  total = longint'(kp_gain) * err * 256 + longint'(ki_gain) * acc;
                  thr = longint'(throttle_q) + (total >>> 24);
                  if (thr < 0) thr = 0;
                  if (thr > longint'(thr_limit)) thr = longint'(thr_limit);
                  throttle_q = thr[14:0];
               end
            end
         end
         cpc_pkg::MODE_ENGAGE: cc_engage();
         cpc_pkg::MODE_DISENGAGE: cc_disengage();
         cpc_pkg::MODE_SET_SPEED: begin
            if (cc_active) begin
               target_q = ev.speed_value;
               saved_q  = ev.speed_value;
            end
         end
         cpc_pkg::MODE_RESUME: begin
            if (saved_q != 16'd0) begin
               target_q    = saved_q;
               resume_pend = 1'b1;
               cc_engage();
            end
         end
         default: ;
      endcase
      res.throttle_cmd = throttle_q;
      res.engaged      = cc_active;
      res.target_speed = target_q;
      res.saved_speed  = saved_q;
      res.ready_pulse  = pulse;
      return res;
   endfunction

   function automatic void check_result(input cpc_pkg::cpc_result_type exp_w,
                                        input cpc_pkg::cpc_result_type got);
      if (got.throttle_cmd !== exp_w.throttle_cmd) begin
         $error("throttle_cmd expected %0d, got %0d", exp_w.throttle_cmd, got.throttle_cmd);
         fail_count++;
      end
      if (got.engaged !== exp_w.engaged) begin
         $error("engaged expected %0d, got %0d", exp_w.engaged, got.engaged);
         fail_count++;
      end
      if (got.target_speed !== exp_w.target_speed) begin
         $error("target_speed expected %0d, got %0d", exp_w.target_speed, got.target_speed);
         fail_count++;
      end
      if (got.saved_speed !== exp_w.saved_speed) begin
         $error("saved_speed expected %0d, got %0d", exp_w.saved_speed, got.saved_speed);
         fail_count++;
      end
      if (got.ready_pulse !== exp_w.ready_pulse) begin
         $error("ready_pulse expected %0d, got %0d", exp_w.ready_pulse, got.ready_pulse);
         fail_count++;
      end
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = event_queue.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.mode           <= next_word.mode;
            req_chan.speed_value    <= next_word.speed_value;
            req_chan.engine_rpm     <= next_word.engine_rpm;
            req_chan.pedal_throttle <= next_word.pedal_throttle;
            req_chan.brake_on       <= next_word.brake_on;
            req_chan.clutch_on      <= next_word.clutch_on;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result ready, with random stalls and the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_chan.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_word.throttle_cmd = rsp_chan.throttle_cmd;
            seen_word.engaged      = rsp_chan.engaged;
            seen_word.target_speed = rsp_chan.target_speed;
            seen_word.saved_speed  = rsp_chan.saved_speed;
            seen_word.ready_pulse  = rsp_chan.ready_pulse;
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result word arrived with no event word outstanding");
               fail_count++;
            end else begin
               check_result(expected_results.pop_front(), seen_word);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            taken_word.mode           = req_chan.mode;
            taken_word.speed_value    = req_chan.speed_value;
            taken_word.engine_rpm     = req_chan.engine_rpm;
            taken_word.pedal_throttle = req_chan.pedal_throttle;
            taken_word.brake_on       = req_chan.brake_on;
            taken_word.clutch_on      = req_chan.clutch_on;
            expected_results.push_back(cruise_predict(taken_word));
            events_taken++;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("cruise_pi_controller_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_event(input logic [2:0] mode, input logic [15:0] spd,
                             input logic [13:0] rpm, input logic [14:0] thr,
                             input logic brk, input logic clu);
      cpc_pkg::cpc_item_type ev;
      ev.mode           = mode;
      ev.speed_value    = spd;
      ev.engine_rpm     = rpm;
      ev.pedal_throttle = thr;
      ev.brake_on       = brk;
      ev.clutch_on      = clu;
      event_queue.push_back(ev);
      phase_items++;
   endtask

   function automatic logic [13:0] pick_rpm();
      int v;
      if ($urandom_range(1)) return 14'($urandom);
      v = int'(rpm_thresh) - 2;
      if (v < 0) v = 0;
      v = v + int'($urandom_range(4));
      if (v > 16383) v = 16383;
      return v[13:0];
   endfunction

   function automatic logic [15:0] near_speed(input logic [15:0] base);
      int v;
      if ($urandom_range(4) == 0) return 16'($urandom);
      v = int'(base) + int'($urandom_range(2048)) - 1024;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   task automatic push_sample(input logic [15:0] spd, input logic brk, input logic clu);
      push_event(cpc_pkg::MODE_SAMPLE, spd, pick_rpm(), 15'($urandom_range(25600)), brk, clu);
   endtask

   task automatic push_noisy(input logic [2:0] mode);
      push_event(mode, 16'($urandom), pick_rpm(), 15'($urandom_range(25600)),
                 1'($urandom), 1'($urandom));
   endtask

   // One engaged stretch: clean samples and ticks, with set speed, resume,
   // repeated engage and pedal drop-outs mixed in.
   task automatic run_drive(input int steps);
      int          r;
      logic [15:0] base;
      logic [1:0]  pedals;
      base = 16'($urandom);
      push_sample(base, 1'b0, 1'b0);
      push_noisy(cpc_pkg::MODE_ENGAGE);
      repeat (steps) begin
         r = $urandom_range(99);
         if (r < 60) begin
            push_sample(near_speed(base), 1'b0, 1'b0);
            push_noisy(cpc_pkg::MODE_TICK);
         end else if (r < 70) begin
            push_noisy(cpc_pkg::MODE_SET_SPEED);
         end else if (r < 78) begin
            push_noisy(cpc_pkg::MODE_TICK);
         end else if (r < 84) begin
            push_noisy(cpc_pkg::MODE_ENGAGE);
         end else if (r < 90) begin
            push_noisy(cpc_pkg::MODE_RESUME);
         end else begin
            pedals = 2'($urandom_range(1, 3));
            push_sample(near_speed(base), pedals[1], pedals[0]);
            push_noisy(cpc_pkg::MODE_TICK);
            push_noisy($urandom_range(1) ? cpc_pkg::MODE_RESUME : cpc_pkg::MODE_ENGAGE);
         end
      end
      push_noisy($urandom_range(1) ? cpc_pkg::MODE_DISENGAGE : cpc_pkg::MODE_TICK);
   endtask

   task automatic run_random(input int count);
      int start;
      start = phase_items;
      while (phase_items - start < count) begin
         if ($urandom_range(99) < 80) begin
            run_drive($urandom_range(2, 14));
         end else begin
            repeat ($urandom_range(1, 6)) push_noisy(3'($urandom));
         end
      end
   endtask

   // Holds a constant speed error long enough for the integral to saturate.
   task automatic run_windup(input logic [15:0] target, input logic [15:0] measured);
      push_noisy(cpc_pkg::MODE_DISENGAGE);
      push_event(cpc_pkg::MODE_SAMPLE, target, 14'h3FFF, 15'd25600, 1'b0, 1'b0);
      push_noisy(cpc_pkg::MODE_ENGAGE);
      push_event(cpc_pkg::MODE_SAMPLE, measured, 14'h3FFF, 15'd0, 1'b0, 1'b0);
      repeat (WindupTicks) push_noisy(cpc_pkg::MODE_TICK);
   endtask

   task automatic write_csr(input cpc_pkg::cpc_csr_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         cpc_pkg::CSR_PROP_GAIN:      kp_gain = val;
         cpc_pkg::CSR_INTEG_GAIN:     ki_gain = val;
         cpc_pkg::CSR_STEP_TIME:      dt_step = val;
         cpc_pkg::CSR_THROTTLE_LIMIT: thr_limit = val[14:0];
         cpc_pkg::CSR_READY_RPM:      rpm_thresh = val[13:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] dt, input logic [14:0] limit,
                            input logic [13:0] rpm);
      write_csr(cpc_pkg::CSR_PROP_GAIN, kp);
      write_csr(cpc_pkg::CSR_INTEG_GAIN, ki);
      write_csr(cpc_pkg::CSR_STEP_TIME, dt);
      write_csr(cpc_pkg::CSR_THROTTLE_LIMIT, {1'b0, limit});
      write_csr(cpc_pkg::CSR_READY_RPM, {2'b00, rpm});
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (event_queue.size() != 0 || expected_results.size() != 0 || req_chan.valid)
         @(negedge clock);
   endtask

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.mode           = cpc_pkg::MODE_SAMPLE;
      req_chan.speed_value    = 16'd0;
      req_chan.engine_rpm     = 14'd0;
      req_chan.pedal_throttle = 15'd0;
      req_chan.brake_on       = 1'b0;
      req_chan.clutch_on      = 1'b0;
      rsp_chan.ready          = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings.
      set_idling(0, 0);
      push_event(cpc_pkg::MODE_TICK, 16'hFFFF, 14'h3FFF, 15'd25600, 1'b1, 1'b1);
      push_event(cpc_pkg::MODE_DISENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SET_SPEED, 16'hFFFF, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_RESUME, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(ModeSpareLo, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(ModeSpareHi, 16'hFFFF, 14'h3FFF, 15'd25600, 1'b1, 1'b1);
      push_event(cpc_pkg::MODE_SAMPLE, 16'hFFFF, 14'd0, 15'd25600, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h0000, 14'h3FFF, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h8000, 14'd49, 15'd12800, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h8000, 14'd50, 15'd12800, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_ENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_ENGAGE, 16'hFFFF, 14'd0, 15'd0, 1'b1, 1'b1);
      push_event(cpc_pkg::MODE_SET_SPEED, 16'hFFFF, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h0000, 14'd3000, 15'd100, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_TICK, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'hFFFF, 14'd3000, 15'd100, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_TICK, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h4000, 14'd3000, 15'd2000, 1'b1, 1'b0);
      push_event(cpc_pkg::MODE_TICK, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_RESUME, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_RESUME, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_DISENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SAMPLE, 16'h2000, 14'd3000, 15'd25600, 1'b0, 1'b1);
      push_event(cpc_pkg::MODE_ENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_TICK, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_ENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_SET_SPEED, 16'h0000, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_DISENGAGE, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      push_event(cpc_pkg::MODE_RESUME, 16'd0, 14'd0, 15'd0, 1'b0, 1'b0);
      wait_drained();

      // Maximum gains and step, limit above full scale: integral windup.
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 14'h3FFF);
      set_idling(0, 0);
      run_windup(16'hFFFF, 16'h0000);
      run_windup(16'h0000, 16'hFFFF);
      run_random(60);
      wait_drained();

      configure(16'd0, 16'd0, 16'd0, 15'd0, 14'd0);
      set_idling(49, 0);
      run_random(150);
      wait_drained();

      configure(16'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom_range(25600)), 14'($urandom_range(200)));
      set_idling(0, 49);
      run_random(200);
      wait_drained();

      configure(cpc_pkg::PropGainReset, cpc_pkg::IntegGainReset, cpc_pkg::StepTimeReset,
                cpc_pkg::ThrottleLimitReset, cpc_pkg::ReadyRpmReset);
      set_idling(24, 24);
      run_random(200);
      wait_drained();

      // Result channel held off while the sender keeps offering words.
      configure(16'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom_range(25600)), 14'($urandom));
      set_idling(0, 0);
      run_random(150);
      hold_left = HoldCycles;
      wait_drained();

      repeat (DrainCycles) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d result words never arrived", expected_results.size());
         fail_count++;
      end
      $display("Checked %0d result words for %0d event words over six register settings,",
               results_seen, events_taken);
      $display("with windup both ways, pedal drop-outs and a %0d-cycle result hold.",
               HoldCycles);
      if (fail_count == 0) begin
         $display("cruise_pi_controller_top: match");
      end else begin
         $display("cruise_pi_controller_top: mismatch");
      end
      $finish;
   end

endmodule
